// ===== design/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int MODE_W = 2;
  localparam int SLOT_IN_W = 4;
  localparam int ARR_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TICK,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SLOT_IN_W-1:0]  slot;
    logic [ARR_W-1:0]      arrival;
    logic [ARR_W-1:0]      burst;
    logic [PRIO_W-1:0]     prio;
  } cmd_t;

  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [ARR_W-1:0]  burst;
    logic [ARR_W-1:0]  remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [TIME_W-1:0]    tick_time;
    logic [SLOT_IN_W-1:0] running_slot;
    logic                 cpu_busy;
    logic                 task_started;
    logic                 task_done;
    logic [TIME_W-1:0]    finish_time;
    logic [TIME_W-1:0]    span_time;
    logic [TIME_W-1:0]    delay_time;
    logic                 all_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCAN,
    ST_LAST,
    ST_EXEC,
    ST_TURN,
    ST_WAIT,
    ST_REPORT
  } state_t;

endpackage

// ===== design/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pps_front.sv =====
// Front end: decodes incoming items into commands and queues them for the engine.
module pps_front #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pps_pkg::MODE_W-1:0]     in_mode,
  input  logic [pps_pkg::SLOT_IN_W-1:0]  in_slot,
  input  logic [pps_pkg::ARR_W-1:0]      in_arrival_time,
  input  logic [pps_pkg::ARR_W-1:0]      in_burst_time,
  input  logic [pps_pkg::PRIO_W-1:0]     in_task_priority,
  output logic                           q_valid,
  output pps_pkg::cmd_t                  q_head,
  input  logic                           q_pop
);
  import pps_pkg::*;

  cmd_t              cmd_in;
  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;
  logic              slot_ok;

  assign slot_ok = 32'(in_slot) < TASK_SLOTS;

  always_comb begin
    cmd_in.slot    = in_slot;
    cmd_in.arrival = in_arrival_time;
    cmd_in.burst   = in_burst_time;
    cmd_in.prio    = in_task_priority;
    unique case (mode_t'(in_mode))
      MODE_LOAD:  cmd_in.kind = slot_ok ? CMD_LOAD : CMD_NOP;
      MODE_TICK:  cmd_in.kind = CMD_TICK;
      MODE_CLEAR: cmd_in.kind = CMD_CLEAR;
      MODE_NONE:  cmd_in.kind = CMD_NOP;
    endcase
  end

  assign busy    = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign push    = start && !busy;
  assign q_valid = cnt_r != '0;
  assign q_head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== design/pps_back.sv =====
// Back end: task table, slot scan, task execution and result reporting.
module pps_back #(
  parameter int TASK_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  pps_pkg::cmd_t  q_head,
  output logic           q_pop,
  output logic           res_valid,
  output pps_pkg::res_t  res
);
  import pps_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [TASK_SLOTS-1:0] active_r;
  logic [CNT_W-1:0]  count_r;
  logic [TIME_W-1:0] time_r, tick_time_r, turn_r, wait_r;
  logic [SLOT_W-1:0] scan_r, cmp_idx_r, best_slot_r, load_idx;
  logic              cmp_vld_r, best_found_r, started_r, done_r;
  entry_t            best_ent_r, rd_ent, wr_ent;
  logic [ENTRY_W-1:0] rd_data;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic              cmp_elig, better, take;
  logic              do_load, do_clear, scan_start, scan_step, do_exec, do_turn;
  logic              do_wait, do_report;
  logic              res_valid_r;
  res_t              res_r;

  assign load_idx = SLOT_W'(cmd_r.slot);
  assign rd_ent   = entry_t'(rd_data);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (cmd_r.kind)
          CMD_TICK:  state_nxt = ST_SCAN;
          CMD_LOAD:  state_nxt = ST_REPORT;
          CMD_CLEAR: state_nxt = ST_REPORT;
          CMD_NOP:   state_nxt = ST_REPORT;
        endcase
      end
      ST_SCAN: begin
        if (scan_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:   state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_TURN;
      ST_TURN:   state_nxt = ST_WAIT;
      ST_WAIT:   state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    do_load    = 1'b0;
    do_clear   = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    do_exec    = 1'b0;
    do_turn    = 1'b0;
    do_wait    = 1'b0;
    do_report  = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_RUN: begin
        do_load    = cmd_r.kind == CMD_LOAD;
        do_clear   = cmd_r.kind == CMD_CLEAR;
        scan_start = cmd_r.kind == CMD_TICK;
      end
      ST_SCAN:   scan_step = 1'b1;
      ST_LAST:   ;
      ST_EXEC:   do_exec = 1'b1;
      ST_TURN:   do_turn = 1'b1;
      ST_WAIT:   do_wait = 1'b1;
      ST_REPORT: do_report = 1'b1;
      default:   ;
    endcase
  end

  assign cmp_elig = cmp_vld_r && active_r[cmp_idx_r] &&
                    (TIME_W'(rd_ent.arrival) <= time_r);
  assign better = !best_found_r || (rd_ent.prio < best_ent_r.prio) ||
                  ((rd_ent.prio == best_ent_r.prio) &&
                   (rd_ent.arrival < best_ent_r.arrival));
  assign take = cmp_elig && better;

  always_comb begin
    if (do_load) begin
      wr_ent.arrival   = cmd_r.arrival;
      wr_ent.burst     = cmd_r.burst;
      wr_ent.remaining = cmd_r.burst;
      wr_ent.prio      = cmd_r.prio;
    end else begin
      wr_ent           = best_ent_r;
      wr_ent.remaining = best_ent_r.remaining - ARR_W'(1);
    end
  end

  assign ram_we    = do_load || (do_exec && best_found_r);
  assign ram_waddr = do_load ? load_idx : best_slot_r;

  pps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TASK_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (scan_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= '0;
      count_r      <= '0;
      time_r       <= '0;
      scan_r       <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      started_r    <= 1'b0;
      done_r       <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= scan_step;
      res_valid_r <= do_report;
      if (q_pop || scan_start) begin
        best_found_r <= 1'b0;
        started_r    <= 1'b0;
        done_r       <= 1'b0;
      end else if (take) begin
        best_found_r <= 1'b1;
      end
      if (scan_start) begin
        scan_r <= '0;
      end else if (scan_step) begin
        scan_r <= scan_r + SLOT_W'(1);
      end
      if (do_load) begin
        active_r[load_idx] <= cmd_r.burst != '0;
        if (active_r[load_idx] && (cmd_r.burst == '0)) begin
          count_r <= count_r - CNT_W'(1);
        end else if (!active_r[load_idx] && (cmd_r.burst != '0)) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (do_clear) begin
        active_r <= '0;
        count_r  <= '0;
        time_r   <= '0;
      end
      if (do_exec) begin
        if (time_r != TIME_MAX) begin
          time_r <= time_r + TIME_W'(1);
        end
        started_r <= best_found_r && (best_ent_r.remaining == best_ent_r.burst);
        done_r    <= best_found_r && (best_ent_r.remaining == ARR_W'(1));
        if (best_found_r && (best_ent_r.remaining == ARR_W'(1))) begin
          active_r[best_slot_r] <= 1'b0;
          count_r               <= count_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r       <= q_head;
      tick_time_r <= time_r;
    end
    cmp_idx_r <= scan_r;
    if (take) begin
      best_slot_r <= cmp_idx_r;
      best_ent_r  <= rd_ent;
    end
    if (do_turn) begin
      turn_r <= time_r - TIME_W'(best_ent_r.arrival);
    end
    if (do_wait) begin
      wait_r <= (turn_r >= TIME_W'(best_ent_r.burst)) ?
                turn_r - TIME_W'(best_ent_r.burst) : '0;
    end
    if (do_report) begin
      res_r.tick_time    <= tick_time_r;
      res_r.running_slot <= best_found_r ? SLOT_IN_W'(best_slot_r) : '0;
      res_r.cpu_busy     <= best_found_r;
      res_r.task_started <= started_r;
      res_r.task_done    <= done_r;
      res_r.finish_time  <= done_r ? time_r : '0;
      res_r.span_time    <= done_r ? turn_r : '0;
      res_r.delay_time   <= done_r ? wait_r : '0;
      res_r.all_done     <= count_r == '0;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r) == int'(count_r))
    else $error("Active count disagrees with the active slot bits.");

  a_done_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.task_done |-> res_r.cpu_busy && !res_r.all_done ||
    res_valid_r && res_r.task_done && res_r.cpu_busy)
    else $error("A task completion was reported without a running task.");

  a_time_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !do_exec && !do_clear |=> $stable(time_r))
    else $error("Time moved outside a tick or a clear.");

  a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
    do_exec && best_found_r |-> active_r[best_slot_r])
    else $error("The chosen task is not an active slot.");

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
// An item is taken when start is high and busy is low; a two-item queue sits in front of
// the scheduling engine, and busy rises only when that queue is full. A load, clear or
// unused-mode item goes straight to its report in the engine; a tick first scans the
// task table, one entry per cycle through the table's single read port. Every item
// yields exactly one result, shown for one cycle with out_valid high; the receiver
// cannot stall it, so it must take each result as it appears.
module preemptive_priority_scheduler #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pps_pkg::MODE_W-1:0]     in_mode,
  input  logic [pps_pkg::SLOT_IN_W-1:0]  in_slot,
  input  logic [pps_pkg::ARR_W-1:0]      in_arrival_time,
  input  logic [pps_pkg::ARR_W-1:0]      in_burst_time,
  input  logic [pps_pkg::PRIO_W-1:0]     in_task_priority,
  output logic                           out_valid,
  output logic [pps_pkg::TIME_W-1:0]     out_tick_time,
  output logic [pps_pkg::SLOT_IN_W-1:0]  out_running_slot,
  output logic                           out_cpu_busy,
  output logic                           out_task_started,
  output logic                           out_task_done,
  output logic [pps_pkg::TIME_W-1:0]     out_completion_time,
  output logic [pps_pkg::TIME_W-1:0]     out_turnaround_time,
  output logic [pps_pkg::TIME_W-1:0]     out_waiting_time,
  output logic                           out_all_done
);
  import pps_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  res_t res;

  pps_front #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_arrival_time  (in_arrival_time),
    .in_burst_time    (in_burst_time),
    .in_task_priority (in_task_priority),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  pps_back #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_tick_time       = res.tick_time;
  assign out_running_slot    = res.running_slot;
  assign out_cpu_busy        = res.cpu_busy;
  assign out_task_started    = res.task_started;
  assign out_task_done       = res.task_done;
  assign out_completion_time = res.finish_time;
  assign out_turnaround_time = res.span_time;
  assign out_waiting_time    = res.delay_time;
  assign out_all_done        = res.all_done;

endmodule
